@@ design/arp_cache_engine_top_assert.svh @@
// assertion macros shared by the arp cache engine rtl
`ifndef ARP_CACHE_ENGINE_TOP_ASSERT_SVH
`define ARP_CACHE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ACE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ACE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ace_pkg.sv @@
// types and constants of the arp cache engine
package ace_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // table entry layout in ram: {ip, mac}
  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int ENTRY_W = IP_W + MAC_W;

  // entry status codes
  localparam logic [1:0] ENT_UNUSED = 2'd0;
  localparam logic [1:0] ENT_USED = 2'd1;
  localparam logic [1:0] ENT_WAITING = 2'd2;

  // result status codes
  localparam logic [2:0] RES_DROPPED = 3'd0;
  localparam logic [2:0] RES_LEARNED = 3'd1;
  localparam logic [2:0] RES_REPLY = 3'd2;
  localparam logic [2:0] RES_HIT = 3'd3;
  localparam logic [2:0] RES_PENDING = 3'd4;
  localparam logic [2:0] RES_REQUEST = 3'd5;

  // transmit operation codes
  localparam logic [1:0] TX_OP_NONE = 2'd0;
  localparam logic [1:0] TX_OP_REQUEST = 2'd1;
  localparam logic [1:0] TX_OP_REPLY = 2'd2;

  // input word kinds
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // arp header checks
  localparam logic [15:0] ARP_OPER_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OPER_REPLY = 16'd2;
  localparam logic [15:0] ARP_MIN_LEN = 16'd28;
  localparam logic [7:0] ARP_HW_LEN = 8'd6;
  localparam logic [7:0] ARP_PROTO_LEN = 8'd4;
  localparam logic [15:0] ARP_HW_ETH = 16'h0001;
  localparam logic [15:0] ARP_PROTO_IPV4 = 16'h0800;
  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  typedef struct packed {
    logic opcode;
    logic [15:0] payload_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0] hw_len;
    logic [7:0] proto_len;
    logic [15:0] oper_code;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0] sender_ip;
    logic [IP_W-1:0] target_ip;
    logic [IP_W-1:0] lookup_ip;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [MAC_W-1:0] found_mac;
    logic tx_valid;
    logic [1:0] tx_oper;
    logic [MAC_W-1:0] tx_dest_mac;
    logic [MAC_W-1:0] tx_target_mac;
    logic [IP_W-1:0] tx_target_ip;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

endpackage

@@ design/ace_ram.sv @@
// generic single-write, registered-read ram
module ace_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/arp_cache_engine_top.sv @@
// arp cache engine: packet learning, request replies and address lookups
//
// Each input word is a received arp packet or a lookup, and gives exactly one result
// word. A packet failing the header checks (length, hw/proto type and length, target
// ip against own_ip, operation request or reply) is dropped with no table scan. Every
// other word is resolved by walking the table one entry per cycle through a single
// ram read port and one 32-bit ip comparator; the walk stops at the first deciding
// entry. in_ready is high only while the engine is idle, so a new word is accepted
// only once the result of the last one is loaded. Entry status lives in flip-flops
// cleared by reset, so no clearing pass is needed; ip and mac live in the ram, and
// an unused entry reads as ip zero. own_ip is written through cfg_we/cfg_wdata; the
// user must write own_ip only while idle, which the block itself does not enforce.
`include "arp_cache_engine_top_assert.svh"

module arp_cache_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ace_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ace_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  // control state
  ace_pkg::state_t state_r, state_nxt;
  logic [ace_pkg::IP_W-1:0] own_ip_r, own_ip_nxt;
  logic [ace_pkg::TABLE_ENTRIES-1:0][1:0] status_r, status_nxt;
  logic [ace_pkg::IDX_W-1:0] victim_r, victim_nxt;
  logic issue_r, issue_nxt;     // read address still being issued
  logic cmp_v_r, cmp_v_nxt;     // ram data of cmp_idx_r is present
  logic out_valid_r, out_valid_nxt;

  // payload and scan bookkeeping
  ace_pkg::in_word_t item_r, item_nxt;
  ace_pkg::out_word_t out_r, out_nxt;
  logic [ace_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [ace_pkg::IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic drop_r, drop_nxt;
  logic match_r, match_nxt;
  logic hit_r, hit_nxt;
  logic [ace_pkg::IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic [ace_pkg::MAC_W-1:0] match_mac_r, match_mac_nxt;
  logic free_v_r, free_v_nxt;
  logic [ace_pkg::IDX_W-1:0] free_idx_r, free_idx_nxt;

  // ram port
  logic ram_we;
  logic [ace_pkg::IDX_W-1:0] ram_waddr;
  logic [ace_pkg::ENTRY_W-1:0] ram_wdata;
  logic [ace_pkg::ENTRY_W-1:0] ram_rdata;

  // entry under compare
  logic [1:0] ent_st;
  logic [ace_pkg::IP_W-1:0] ent_ip;
  logic [ace_pkg::IP_W-1:0] key_ip;
  logic ip_eq;
  logic pkt_ok;
  logic [ace_pkg::IDX_W-1:0] pick;

  ace_ram #(
    .WIDTH (ace_pkg::ENTRY_W),
    .DEPTH (ace_pkg::TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // header checks on the incoming word
  assign pkt_ok = (in_data.payload_len >= ace_pkg::ARP_MIN_LEN)
               && (in_data.hw_len == ace_pkg::ARP_HW_LEN)
               && (in_data.proto_len == ace_pkg::ARP_PROTO_LEN)
               && (in_data.hw_type == ace_pkg::ARP_HW_ETH)
               && (in_data.proto_type == ace_pkg::ARP_PROTO_IPV4)
               && (in_data.target_ip == own_ip_r)
               && ((in_data.oper_code == ace_pkg::ARP_OPER_REQUEST)
                   || (in_data.oper_code == ace_pkg::ARP_OPER_REPLY));

  // the one shared comparator; an unused entry always reads as ip zero
  assign ent_st = status_r[cmp_idx_r];
  assign ent_ip = (ent_st == ace_pkg::ENT_UNUSED) ? '0
                : ram_rdata[ace_pkg::ENTRY_W-1:ace_pkg::MAC_W];
  assign key_ip = (item_r.opcode == ace_pkg::OP_LOOKUP) ? item_r.lookup_ip
                : item_r.sender_ip;
  assign ip_eq = (ent_ip == key_ip);

  // learning slot: ip match, else last unused, else round-robin victim
  assign pick = match_r ? match_idx_r : (free_v_r ? free_idx_r : victim_r);

  assign in_ready = (state_r == ace_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r;
    own_ip_nxt = own_ip_r;
    status_nxt = status_r;
    victim_nxt = victim_r;
    issue_nxt = issue_r;
    cmp_v_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    item_nxt = item_r;
    out_nxt = out_r;
    idx_nxt = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    drop_nxt = drop_r;
    match_nxt = match_r;
    hit_nxt = hit_r;
    match_idx_nxt = match_idx_r;
    match_mac_nxt = match_mac_r;
    free_v_nxt = free_v_r;
    free_idx_nxt = free_idx_r;
    ram_we = 1'b0;
    ram_waddr = pick;
    ram_wdata = {item_r.sender_ip, item_r.sender_mac};

    if (cfg_we) begin
      own_ip_nxt = cfg_wdata;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ace_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          idx_nxt = '0;
          issue_nxt = 1'b1;
          match_nxt = 1'b0;
          hit_nxt = 1'b0;
          free_v_nxt = 1'b0;
          drop_nxt = (in_data.opcode == ace_pkg::OP_PACKET) && !pkt_ok;
          state_nxt = drop_nxt ? ace_pkg::S_FIN : ace_pkg::S_SCAN;
        end
      end

      ace_pkg::S_SCAN: begin
        // issue one read per cycle
        if (issue_r) begin
          cmp_v_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          if (idx_r == ace_pkg::LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + ace_pkg::IDX_W'(1);
          end
        end
        // compare the entry read last cycle
        if (cmp_v_r) begin
          if (item_r.opcode == ace_pkg::OP_PACKET) begin
            if (ip_eq) begin
              match_nxt = 1'b1;
              match_idx_nxt = cmp_idx_r;
            end else if (ent_st == ace_pkg::ENT_UNUSED) begin
              free_v_nxt = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end
          end else begin
            if (ent_st == ace_pkg::ENT_UNUSED) begin
              free_v_nxt = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end else if (ip_eq && (ent_st == ace_pkg::ENT_USED
                                   || ent_st == ace_pkg::ENT_WAITING)) begin
              match_nxt = 1'b1;
              hit_nxt = (ent_st == ace_pkg::ENT_USED);
              match_mac_nxt = ram_rdata[ace_pkg::MAC_W-1:0];
            end
          end
          if (match_nxt || cmp_idx_r == ace_pkg::LAST_IDX) begin
            state_nxt = ace_pkg::S_FIN;
            issue_nxt = 1'b0;
            cmp_v_nxt = 1'b0;
          end
        end
      end

      ace_pkg::S_FIN: begin
        // table update and result load happen together once the output is free
        if (!out_valid_r || out_ready) begin
          out_nxt = '0;
          out_valid_nxt = 1'b1;
          state_nxt = ace_pkg::S_IDLE;
          if (item_r.opcode == ace_pkg::OP_PACKET) begin
            if (drop_r) begin
              out_nxt.status = ace_pkg::RES_DROPPED;
            end else begin
              ram_we = 1'b1;
              status_nxt[pick] = ace_pkg::ENT_USED;
              if (!match_r && !free_v_r) begin
                victim_nxt = (victim_r == ace_pkg::LAST_IDX) ? '0
                           : victim_r + ace_pkg::IDX_W'(1);
              end
              if (item_r.oper_code == ace_pkg::ARP_OPER_REQUEST) begin
                out_nxt.status = ace_pkg::RES_REPLY;
                out_nxt.tx_valid = 1'b1;
                out_nxt.tx_oper = ace_pkg::TX_OP_REPLY;
                out_nxt.tx_dest_mac = item_r.sender_mac;
                out_nxt.tx_target_mac = item_r.sender_mac;
                out_nxt.tx_target_ip = item_r.sender_ip;
              end else begin
                out_nxt.status = ace_pkg::RES_LEARNED;
              end
            end
          end else if (match_r) begin
            if (hit_r) begin
              out_nxt.status = ace_pkg::RES_HIT;
              out_nxt.found_mac = match_mac_r;
            end else begin
              out_nxt.status = ace_pkg::RES_PENDING;
            end
          end else begin
            // miss: claim the last unused entry, if any, and broadcast a request
            if (free_v_r) begin
              ram_we = 1'b1;
              ram_waddr = free_idx_r;
              ram_wdata = {item_r.lookup_ip, {ace_pkg::MAC_W{1'b0}}};
              status_nxt[free_idx_r] = ace_pkg::ENT_WAITING;
            end
            out_nxt.status = ace_pkg::RES_REQUEST;
            out_nxt.tx_valid = 1'b1;
            out_nxt.tx_oper = ace_pkg::TX_OP_REQUEST;
            out_nxt.tx_dest_mac = ace_pkg::BCAST_MAC;
            out_nxt.tx_target_ip = item_r.lookup_ip;
          end
        end
      end

      default: begin
        state_nxt = ace_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ace_pkg::S_IDLE;
      own_ip_r <= '0;
      status_r <= '0;
      victim_r <= '0;
      issue_r <= 1'b0;
      cmp_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      own_ip_r <= own_ip_nxt;
      status_r <= status_nxt;
      victim_r <= victim_nxt;
      issue_r <= issue_nxt;
      cmp_v_r <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r <= out_nxt;
    idx_r <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    drop_r <= drop_nxt;
    match_r <= match_nxt;
    hit_r <= hit_nxt;
    match_idx_r <= match_idx_nxt;
    match_mac_r <= match_mac_nxt;
    free_v_r <= free_v_nxt;
    free_idx_r <= free_idx_nxt;
  end

  `ACE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, state_r != ace_pkg::S_IDLE, "engine idle right after accepting a word")
  `ACE_ASSERT_NOW(a_result_from_fin, $rose(out_valid_r), $past(state_r) == ace_pkg::S_FIN, "result word raised outside the finish step")
  `ACE_ASSERT_NOW(a_tx_needs_status, out_valid_r && out_r.tx_valid, out_r.status == ace_pkg::RES_REPLY || out_r.status == ace_pkg::RES_REQUEST, "transmit flagged with a status that sends nothing")
  `ACE_ASSERT_NOW(a_victim_range, 1'b1, victim_r <= ace_pkg::LAST_IDX, "victim pointer beyond the table")

endmodule
